[sv/cidrp_pkg.sv]
// Shared types and constants for the CIDR text parser.
package cidrp_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned OCT_IDX_W   = 3;
   localparam int unsigned PREFIX_W    = 6;
   localparam logic [5:0]  FULL_PREFIX = 6'd32;
   localparam logic [2:0]  OCTETS      = 3'd4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_PAST_TOP   = 2'd1;
   localparam logic [1:0] STATUS_BAD_PREFIX = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]    address_accum;
      logic [ADDR_W-1:0]    digit_accum;
      logic [OCT_IDX_W-1:0] octet_index;
      logic                 in_prefix;
      logic                 digits_stopped;
      logic                 prefix_given;
   } scan_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   base;
      logic [PREFIX_W-1:0] prefix;
      logic                prefix_over;
   } scan_close_type;

endpackage

[sv/cidrp_scan.sv]
// Per-character scan step: next parser state and the closing summary.
module cidrp_scan import cidrp_pkg::*; (
   input  scan_state_type state_cur,
   input  logic [7:0]     text_char,
   output scan_state_type state_nxt,
   output scan_close_type close_info
);

   logic              is_digit;
   logic              is_dot;
   logic              is_slash;
   logic              take_digit;
   logic [ADDR_W-1:0] digit_mac;
   logic [ADDR_W-1:0] digit_new;
   logic [ADDR_W-1:0] part;
   logic [ADDR_W-1:0] addr_sum;
   logic              room;
   logic [4:0]        shift;

   always_comb begin
      is_digit   = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
      is_dot     = !state_cur.in_prefix && (text_char == CHAR_DOT);
      is_slash   = !state_cur.in_prefix && (text_char == CHAR_SLASH);
      take_digit = is_digit && !state_cur.digits_stopped;
      digit_mac  = (state_cur.digit_accum << 3) + (state_cur.digit_accum << 1)
                   + {{(ADDR_W-8){1'b0}}, text_char - CHAR_ZERO};
      digit_new  = take_digit ? digit_mac : state_cur.digit_accum;
      room       = state_cur.octet_index < OCTETS;
      shift      = {~state_cur.octet_index[1:0], 3'b000};
      part       = room ? (digit_new << shift) : '0;
      addr_sum   = state_cur.address_accum + part;

      state_nxt             = state_cur;
      state_nxt.digit_accum = digit_new;
      if (is_digit) begin
         if (take_digit && state_cur.in_prefix) begin
            state_nxt.prefix_given = 1'b1;
         end
      end else if (is_dot || is_slash) begin
         state_nxt.address_accum  = addr_sum;
         state_nxt.digit_accum    = '0;
         state_nxt.digits_stopped = 1'b0;
         if (room) begin
            state_nxt.octet_index = state_cur.octet_index + 3'd1;
         end
         if (is_slash) begin
            state_nxt.in_prefix = 1'b1;
         end
      end else begin
         state_nxt.digits_stopped = 1'b1;
      end

      close_info.base        = state_cur.in_prefix ? state_cur.address_accum : addr_sum;
      close_info.prefix      = FULL_PREFIX;
      close_info.prefix_over = 1'b0;
      if (state_nxt.in_prefix && state_nxt.prefix_given) begin
         close_info.prefix      = digit_new[PREFIX_W-1:0];
         close_info.prefix_over = (|digit_new[ADDR_W-1:PREFIX_W])
                                  || (digit_new[PREFIX_W-1:0] > FULL_PREFIX);
      end
   end

endmodule

[sv/cidrp_block.sv]
// Address count and status from the parsed base and prefix length.
module cidrp_block import cidrp_pkg::*; (
   input  scan_close_type    close_info,
   output logic [ADDR_W-1:0] address_count,
   output logic [1:0]        status
);

   logic [4:0]        host_bits;
   logic [ADDR_W-1:0] count_m1;
   logic [ADDR_W:0]   top_sum;

   always_comb begin
      host_bits = 5'(FULL_PREFIX - close_info.prefix);
      if (close_info.prefix == '0) begin
         address_count = '1;
         count_m1      = {{(ADDR_W-1){1'b1}}, 1'b0};
      end else begin
         address_count = {{(ADDR_W-1){1'b0}}, 1'b1} << host_bits;
         count_m1      = address_count - {{(ADDR_W-1){1'b0}}, 1'b1};
      end
      top_sum = {1'b0, close_info.base} + {1'b0, count_m1};
      status  = top_sum[ADDR_W] ? STATUS_PAST_TOP : STATUS_OK;
      if (close_info.prefix_over) begin
         address_count = '0;
         status        = STATUS_BAD_PREFIX;
      end
   end

endmodule

[sv/cidr_text_parser_unit.sv]
// IPv4 CIDR text parser: one character per item, base address and count on the last.
//
// Takes one character every cycle with no gaps, unless a final character waits on a
// stalled result. Each character is held in an input register while a single pass of
// logic updates the parse state; the item marked final also loads the result register
// as it leaves the input register. A stalled result holds back only final characters;
// other characters keep flowing into the parse state while the result waits.
module cidr_text_parser_unit import cidrp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_text_char,
   input  logic              req_is_final,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_base_address,
   output logic [ADDR_W-1:0] rsp_address_count,
   output logic [1:0]        rsp_status
);

   logic              item_valid_ff, item_valid_in;
   logic [7:0]        item_char_ff;
   logic              item_final_ff;
   scan_state_type    state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] base_ff, count_ff;
   logic [1:0]        status_ff;

   scan_state_type    state_step;
   scan_close_type    close_info;
   logic [ADDR_W-1:0] count_calc;
   logic [1:0]        status_calc;
   logic              advance;
   logic              emit;

   cidrp_scan u_scan (
      .state_cur  (state_ff),
      .text_char  (item_char_ff),
      .state_nxt  (state_step),
      .close_info (close_info)
   );

   cidrp_block u_block (
      .close_info    (close_info),
      .address_count (count_calc),
      .status        (status_calc)
   );

   always_comb begin
      advance       = item_valid_ff && (!item_final_ff || !rsp_valid_ff || rsp_ready);
      emit          = advance && item_final_ff;
      req_ready     = !item_valid_ff || advance;
      item_valid_in = (req_valid && req_ready) || (item_valid_ff && !advance);
      rsp_valid_in  = emit || (rsp_valid_ff && !rsp_ready);
      state_in      = state_ff;
      if (advance) begin
         state_in = item_final_ff ? '0 : state_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_char_ff  <= req_text_char;
         item_final_ff <= req_is_final;
      end
      if (emit) begin
         base_ff   <= close_info.base;
         count_ff  <= count_calc;
         status_ff <= status_calc;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_base_address  = base_ff;
   assign rsp_address_count = count_ff;
   assign rsp_status        = status_ff;

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid)
      else $error("final item did not load a result");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      emit |=> (state_ff.octet_index == '0) && !state_ff.in_prefix && !state_ff.prefix_given)
      else $error("parse state not cleared after final item");

   a_octet_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.octet_index <= OCTETS)
      else $error("octet index out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !emit)
      else $error("result overwritten while stalled");

endmodule
